[rtl/pchm_pkg.sv]
package pchm_pkg;

  localparam int MAP_SIDE_DEF = 1024;

  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z  = 3'd5;

  localparam logic [23:0] SCALE_ONE = 24'h010000;

  // item kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] z_mm;
    logic               z_valid;
    logic [9:0]         read_col;
    logic [9:0]         read_row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] height;
    logic [19:0] cell_index;
  } out_item_t;

  // mapped item from the transform stage
  typedef struct packed {
    logic        hit;
    logic [15:0] height;
    logic [19:0] cell_index;
  } xf_res_t;

endpackage

[rtl/pchm_xform.sv]
module pchm_xform #(
  parameter int MAP_SIDE = pchm_pkg::MAP_SIDE_DEF
) (
  input  logic                                   clk,
  input  logic                                   en_mul,
  input  logic                                   en_adr,
  input  pchm_pkg::in_item_t                     item,
  input  logic signed [15:0]                     origin_x,
  input  logic [23:0]                            scale_x,
  input  logic signed [15:0]                     origin_y,
  input  logic [23:0]                            scale_y,
  input  logic signed [15:0]                     origin_z,
  input  logic [23:0]                            scale_z,
  output pchm_pkg::xf_res_t                      res,
  output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]   idx
);
  import pchm_pkg::*;

  localparam int CELLS = MAP_SIDE * MAP_SIDE;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(MAP_SIDE);
  localparam logic [23:0] SIDE_Q = 24'(MAP_SIDE);
  localparam logic [12:0] SIDE_R = 13'(MAP_SIDE);

  logic signed [16:0] dx, dy, dz;
  logic [39:0] prod_x_r, prod_y_r, prod_z_r;
  logic        neg_x_r, neg_y_r, neg_z_r;
  logic [23:0] qx, qy, qz;
  logic        col_ok, row_ok, rd_ok;
  logic [15:0] hgt;
  logic [AW-1:0] pt_idx, rd_idx;
  logic [31:0] rd_lin;
  xf_res_t     res_r;
  logic [AW-1:0] idx_r;

  assign dx = {item.x_mm[15], item.x_mm} - {origin_x[15], origin_x};
  assign dy = {item.y_mm[15], item.y_mm} - {origin_y[15], origin_y};
  assign dz = {item.z_mm[15], item.z_mm} - {origin_z[15], origin_z};

  // one 16x24 product per axis, negative offsets flagged
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_x_r <= 40'(dx[15:0]) * 40'(scale_x);
      prod_y_r <= 40'(dy[15:0]) * 40'(scale_y);
      prod_z_r <= 40'(dz[15:0]) * 40'(scale_z);
      neg_x_r  <= dx[16];
      neg_y_r  <= dy[16];
      neg_z_r  <= dz[16];
    end
  end

  assign qx = prod_x_r[39:16];
  assign qy = prod_y_r[39:16];
  assign qz = prod_z_r[39:16];

  assign col_ok = !neg_x_r && (qx < SIDE_Q);
  assign row_ok = !neg_y_r && (qy < SIDE_Q);

  always_comb begin
    if (neg_z_r) begin
      hgt = 16'h0000;
    end else if (qz[23:16] != 8'h00) begin
      hgt = 16'hffff;
    end else begin
      hgt = qz[15:0];
    end
  end

  assign pt_idx = AW'(AW'(qy[CW-1:0]) * AW'(MAP_SIDE) + AW'(qx[CW-1:0]));

  assign rd_ok  = ({3'b000, item.read_col} < SIDE_R) && ({3'b000, item.read_row} < SIDE_R);
  assign rd_lin = 32'(item.read_row) * 32'(MAP_SIDE) + 32'(item.read_col);
  assign rd_idx = rd_lin[AW-1:0];

  always_ff @(posedge clk) begin
    if (en_adr) begin
      if (item.kind == KIND_READ) begin
        res_r.hit <= rd_ok;
        idx_r     <= rd_idx;
      end else begin
        res_r.hit <= item.z_valid && col_ok && row_ok;
        idx_r     <= pt_idx;
      end
      res_r.height     <= hgt;
      res_r.cell_index <= rd_lin[19:0];
    end
  end

  assign res = res_r;
  assign idx = idx_r;

endmodule

[rtl/point_cloud_height_map_raster_top.sv]
// Height-map rasterizer with a max z-buffer over a MAP_SIDE x MAP_SIDE map held in
// one single-port-write, registered-read memory. Point beats (kind 0) are scaled per
// axis as (coord - origin) * scale / 65536; points off the map or without depth are
// dropped, and a cell keeps the larger of its stored and new height (saturated to
// 0..65535). Read beats (kind 1) return one result with the cell's height and index,
// and clear the cell. Each item passes through multiply, index, memory read, then
// compare and write back before the next acceptance, one item in flight at a time.
// After reset the map is swept to zero, one cell per cycle; in_ready stays low
// during that sweep while configuration writes are taken as usual. A result
// waiting on out_ready does not hold off the next item until that item reaches
// write back, and then only if that item is a read beat.
module point_cloud_height_map_raster_top #(
  parameter int MAP_SIDE = pchm_pkg::MAP_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pchm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pchm_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [pchm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pchm_pkg::CFG_W-1:0]          cfg_wdata
);
  import pchm_pkg::*;

  localparam int CELLS = MAP_SIDE * MAP_SIDE;
  localparam int AW = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ADR   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_WB    = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic signed [15:0] origin_x_r, origin_y_r, origin_z_r;
  logic [23:0]        scale_x_r, scale_y_r, scale_z_r;

  in_item_t    item_r;
  xf_res_t     res;
  logic [AW-1:0] idx;

  logic [15:0] map_mem [CELLS];
  logic [15:0] rd_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0] mem_wd;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  logic        out_free;
  logic        wb_done;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign wb_done  = (state_r == ST_WB) && ((item_r.kind == KIND_POINT) || out_free);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= 16'sd0;
      scale_x_r  <= SCALE_ONE;
      origin_y_r <= 16'sd0;
      scale_y_r  <= SCALE_ONE;
      origin_z_r <= 16'sd0;
      scale_z_r  <= SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x_r <= cfg_wdata[15:0];
        CFG_SCALE_X:  scale_x_r  <= cfg_wdata;
        CFG_ORIGIN_Y: origin_y_r <= cfg_wdata[15:0];
        CFG_SCALE_Y:  scale_y_r  <= cfg_wdata;
        CFG_ORIGIN_Z: origin_z_r <= cfg_wdata[15:0];
        CFG_SCALE_Z:  scale_z_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  pchm_xform #(
    .MAP_SIDE (MAP_SIDE)
  ) u_xform (
    .clk      (clk),
    .en_mul   (state_r == ST_MUL),
    .en_adr   (state_r == ST_ADR),
    .item     (item_r),
    .origin_x (origin_x_r),
    .scale_x  (scale_x_r),
    .origin_y (origin_y_r),
    .scale_y  (scale_y_r),
    .origin_z (origin_z_r),
    .scale_z  (scale_z_r),
    .res      (res),
    .idx      (idx)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ADR;
      ST_ADR: state_nxt = ST_RD;
      ST_RD:  state_nxt = ST_WB;
      ST_WB: begin
        if (wb_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // write port: clearing sweep, max update, or clear on read
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = 16'h0000;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
    end else if (wb_done) begin
      if (item_r.kind == KIND_READ) begin
        mem_we = res.hit;
      end else begin
        mem_we = res.hit && (res.height > rd_r);
        mem_wd = res.height;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_r <= map_mem[idx];
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (wb_done && (item_r.kind == KIND_READ)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_done && (item_r.kind == KIND_READ)) begin
      out_data_r.height     <= res.hit ? rd_r : 16'h0000;
      out_data_r.cell_index <= res.cell_index;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
